// ===== design/dlr_pkg.sv =====
// Shared types and constants of the dithered line rasterizer.
`default_nettype none

package dlr_pkg;

  localparam int ScreenWidthDef  = 400;
  localparam int ScreenHeightDef = 240;

  localparam int CoordW    = 11;
  localparam int DeltaW    = 12;
  localparam int ReadAddrW = 14;
  localparam int ReadDataW = 8;
  localparam int CountW    = 12;
  localparam int InDataW   = 64;
  localparam int OutDataW  = 24;

  localparam int CmdQueueDepth = 2;
  localparam int MaxPending    = 5;

  localparam logic [ReadDataW-1:0] PixelBit = 8'h80;

  typedef enum logic {
    KIND_DRAW,
    KIND_READ
  } kind_e;

  typedef enum logic [1:0] {
    PEN_CLEAR,
    PEN_SET,
    PEN_ODD,
    PEN_EVEN
  } pen_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_WRITE,
    ST_RESP
  } back_state_e;

  typedef struct packed {
    kind_e                kind;
    logic [ReadAddrW-1:0] read_address;
    logic                 steep;
    logic                 ystep_neg;
    pen_e                 pen;
    logic [CoordW-1:0]    maj_start;
    logic [CoordW-1:0]    min_start;
    logic [CoordW-1:0]    dx;
    logic [CoordW-1:0]    dy;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/dithered_line_rasterizer.sv =====
// Top level of the dithered line rasterizer.
//
// A one-bit-per-pixel frame buffer of (SCREEN_WIDTH+7)/8 bytes per row, MSB first, with a
// Bresenham line engine. A draw beat returns the number of pixels that landed on screen; a read
// beat returns one frame byte. After reset the frame memory is swept to zero one byte per cycle,
// (SCREEN_WIDTH+7)/8*SCREEN_HEIGHT bytes (12000 at the defaults), and s_axis_tready_o stays low
// until the sweep ends. Each pixel of a draw is a read-modify-write of the single frame memory.
// The front end sets up the next item in its own stage and the queue holds two more while the
// engine is busy, so per-item setup hides behind the previous line.
`default_nettype none

module dithered_line_rasterizer import dlr_pkg::*; #(
  parameter int SCREEN_WIDTH  = ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // x_start[10:0], y_start[21:11], x_end[32:22], y_end[43:33], pen_mode[45:44],
  // read_address[59:46], zero[63:60]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // kind[0]
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // read_data[7:0], pixels_in_view[19:8], zero[23:20]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic                 clearing;
  logic                 front_valid, front_ready;
  cmd_t                 front_cmd;
  logic                 back_valid, back_ready;
  cmd_t                 back_cmd;
  logic [ReadDataW-1:0] out_read_data;
  logic [CountW-1:0]    out_count;

  dlr_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .clearing_i        (clearing),
    .in_valid_i        (s_axis_tvalid_i),
    .in_ready_o        (s_axis_tready_o),
    .in_kind_i         (s_axis_tuser_i),
    .in_x_start_i      (s_axis_tdata_i[10:0]),
    .in_y_start_i      (s_axis_tdata_i[21:11]),
    .in_x_end_i        (s_axis_tdata_i[32:22]),
    .in_y_end_i        (s_axis_tdata_i[43:33]),
    .in_pen_mode_i     (s_axis_tdata_i[45:44]),
    .in_read_address_i (s_axis_tdata_i[59:46]),
    .cmd_valid_o       (front_valid),
    .cmd_ready_i       (front_ready),
    .cmd_o             (front_cmd)
  );

  dlr_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  dlr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (back_valid),
    .cmd_ready_o     (back_ready),
    .cmd_i           (back_cmd),
    .clearing_o      (clearing),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_read_data_o (out_read_data),
    .out_count_o     (out_count)
  );

  assign m_axis_tdata_o = {(OutDataW - ReadDataW - CountW)'(0), out_count, out_read_data};

endmodule

`default_nettype wire

// ===== design/dlr_front.sv =====
// Front end: accepts beats, turns draw items into ordered line setups and passes read items on.
`default_nettype none

module dlr_front import dlr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clearing_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     in_kind_i,
  input  logic signed [CoordW-1:0] in_x_start_i,
  input  logic signed [CoordW-1:0] in_y_start_i,
  input  logic signed [CoordW-1:0] in_x_end_i,
  input  logic signed [CoordW-1:0] in_y_end_i,
  input  logic [1:0]               in_pen_mode_i,
  input  logic [ReadAddrW-1:0]     in_read_address_i,
  output logic                     cmd_valid_o,
  input  logic                     cmd_ready_i,
  output cmd_t                     cmd_o
);

  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_kind_q;
  logic [1:0]           s1_pen_q;
  logic [ReadAddrW-1:0] s1_read_address_q;
  logic [CoordW-1:0]    s1_xs_q, s1_ys_q, s1_xe_q, s1_ye_q;
  logic [DeltaW-1:0]    s1_dxr_q, s1_dyr_q;

  logic              accept, push;
  logic [DeltaW-1:0] adx, ady, minor_raw;
  logic              steep, maj_neg;

  assign push        = s1_valid_q && cmd_ready_i;
  assign in_ready_o  = !clearing_i && (!s1_valid_q || cmd_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign s1_valid_d  = accept || (s1_valid_q && !push);
  assign cmd_valid_o = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q         <= in_kind_i;
      s1_pen_q          <= in_pen_mode_i;
      s1_read_address_q <= in_read_address_i;
      s1_xs_q           <= in_x_start_i;
      s1_ys_q           <= in_y_start_i;
      s1_xe_q           <= in_x_end_i;
      s1_ye_q           <= in_y_end_i;
      s1_dxr_q          <= {in_x_end_i[CoordW-1], in_x_end_i}
                         - {in_x_start_i[CoordW-1], in_x_start_i};
      s1_dyr_q          <= {in_y_end_i[CoordW-1], in_y_end_i}
                         - {in_y_start_i[CoordW-1], in_y_start_i};
    end
  end

  always_comb begin
    adx       = s1_dxr_q[DeltaW-1] ? (~s1_dxr_q + DeltaW'(1)) : s1_dxr_q;
    ady       = s1_dyr_q[DeltaW-1] ? (~s1_dyr_q + DeltaW'(1)) : s1_dyr_q;
    steep     = ady > adx;
    maj_neg   = steep ? s1_dyr_q[DeltaW-1] : s1_dxr_q[DeltaW-1];
    minor_raw = steep ? s1_dxr_q : s1_dyr_q;

    cmd_o.kind         = kind_e'(s1_kind_q);
    cmd_o.read_address = s1_read_address_q;
    cmd_o.steep        = steep;
    cmd_o.ystep_neg    = minor_raw[DeltaW-1] ^ maj_neg;
    cmd_o.pen          = pen_e'(s1_pen_q);
    if (steep) begin
      cmd_o.maj_start = maj_neg ? s1_ye_q : s1_ys_q;
      cmd_o.min_start = maj_neg ? s1_xe_q : s1_xs_q;
      cmd_o.dx        = ady[CoordW-1:0];
      cmd_o.dy        = adx[CoordW-1:0];
    end else begin
      cmd_o.maj_start = maj_neg ? s1_xe_q : s1_xs_q;
      cmd_o.min_start = maj_neg ? s1_ye_q : s1_ys_q;
      cmd_o.dx        = adx[CoordW-1:0];
      cmd_o.dy        = ady[CoordW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/dlr_cmd_fifo.sv =====
// Short command queue between the front end and the pixel engine.
`default_nettype none

module dlr_cmd_fifo import dlr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int PtrW = (CmdQueueDepth > 1) ? $clog2(CmdQueueDepth) : 1;
  localparam int CntW = $clog2(CmdQueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CmdQueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CmdQueueDepth);

  cmd_t            slot_q [CmdQueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = cnt_q != FullCnt;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/dlr_back.sv =====
// Pixel engine: frame memory, clearing pass, line walk, byte reads and result register.
`default_nettype none

module dlr_back import dlr_pkg::*; #(
  parameter int SCREEN_WIDTH  = ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  cmd_t                 cmd_i,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ReadDataW-1:0] out_read_data_o,
  output logic [CountW-1:0]    out_count_o
);

  localparam int RowBytes   = (SCREEN_WIDTH + 7) / 8;
  localparam int StoreBytes = RowBytes * SCREEN_HEIGHT;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreBytes - 1);

  back_state_e state_q, state_d;

  logic [ReadDataW-1:0] frame_store_q [StoreBytes];
  logic [ReadDataW-1:0] rdata_q;
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr;
  logic [ReadDataW-1:0] mem_wdata;

  logic [AddrW-1:0]     clr_q, clr_d;
  logic [AddrW-1:0]     addr_q, addr_d;
  logic                 rd_ok_q, rd_ok_d;
  kind_e                kind_q, kind_d;
  logic                 steep_q, steep_d;
  logic                 ystep_neg_q, ystep_neg_d;
  pen_e                 pen_q, pen_d;
  logic [CoordW-1:0]    dx_q, dx_d, dy_q, dy_d;
  logic [CoordW-1:0]    maj_q, maj_d, min_q, min_d;
  logic [DeltaW-1:0]    err_q, err_d;
  logic [CoordW-1:0]    left_q, left_d;
  logic                 last_q, last_d;
  logic [ReadDataW-1:0] mask_q, mask_d;
  logic                 on_q, on_d;
  logic                 view_q, view_d;
  logic [CountW-1:0]    cnt_q, cnt_d;

  logic                 out_valid_q, out_valid_d;
  logic [ReadDataW-1:0] out_read_data_q, out_read_data_d;
  logic [CountW-1:0]    out_count_q, out_count_d;

  logic                 gen_en, out_load;
  logic [CoordW-1:0]    px, py;
  logic                 in_view_c, on_c;
  logic [AddrW-1:0]     pix_addr_c;
  logic [ReadDataW-1:0] mask_c;
  logic [DeltaW-1:0]    err_dec, err_step_c;
  logic [CoordW-1:0]    min_step_c;

  assign cmd_ready_o     = state_q == ST_IDLE;
  assign clearing_o      = state_q == ST_CLEAR;
  assign out_valid_o     = out_valid_q;
  assign out_read_data_o = out_read_data_q;
  assign out_count_o     = out_count_q;

  always_comb begin
    px = steep_q ? min_q : maj_q;
    py = steep_q ? maj_q : min_q;
    in_view_c = !px[CoordW-1] && ({1'b0, px[CoordW-2:0]} < CoordW'(SCREEN_WIDTH))
             && !py[CoordW-1] && ({1'b0, py[CoordW-2:0]} < CoordW'(SCREEN_HEIGHT));
    pix_addr_c = AddrW'(32'(py[CoordW-2:0]) * 32'(RowBytes) + 32'(px[CoordW-2:3]));
    mask_c     = PixelBit >> px[2:0];
    case (pen_q)
      PEN_CLEAR: on_c = 1'b0;
      PEN_SET:   on_c = 1'b1;
      PEN_ODD:   on_c = maj_q[0];
      default:   on_c = !maj_q[0];
    endcase
    err_dec    = err_q - {1'b0, dy_q};
    err_step_c = err_dec[DeltaW-1] ? err_dec + {1'b0, dx_q} : err_dec;
    if (err_dec[DeltaW-1]) begin
      min_step_c = ystep_neg_q ? min_q - CoordW'(1) : min_q + CoordW'(1);
    end else begin
      min_step_c = min_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    rd_ok_d     = rd_ok_q;
    kind_d      = kind_q;
    steep_d     = steep_q;
    ystep_neg_d = ystep_neg_q;
    pen_d       = pen_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    maj_d       = maj_q;
    min_d       = min_q;
    err_d       = err_q;
    left_d      = left_q;
    last_d      = last_q;
    mask_d      = mask_q;
    on_d        = on_q;
    view_d      = view_q;
    cnt_d       = cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = on_q ? (rdata_q | mask_q) : (rdata_q & ~mask_q);
    gen_en      = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          kind_d = cmd_i.kind;
          cnt_d  = '0;
          if (cmd_i.kind == KIND_READ) begin
            addr_d  = AddrW'(cmd_i.read_address);
            rd_ok_d = 32'(cmd_i.read_address) < 32'(StoreBytes);
            state_d = ST_READ;
          end else begin
            steep_d     = cmd_i.steep;
            ystep_neg_d = cmd_i.ystep_neg;
            pen_d       = cmd_i.pen;
            dx_d        = cmd_i.dx;
            dy_d        = cmd_i.dy;
            maj_d       = cmd_i.maj_start;
            min_d       = cmd_i.min_start;
            err_d       = DeltaW'(cmd_i.dx >> 1);
            left_d      = cmd_i.dx;
            state_d     = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        gen_en  = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        state_d = (kind_q == KIND_READ) ? ST_RESP : ST_WRITE;
      end
      ST_WRITE: begin
        mem_we = view_q;
        if (view_q) begin
          cnt_d = cnt_q + CountW'(1);
        end
        if (last_q) begin
          state_d = ST_RESP;
        end else begin
          gen_en  = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (gen_en) begin
      addr_d = pix_addr_c;
      mask_d = mask_c;
      on_d   = on_c;
      view_d = in_view_c;
      maj_d  = maj_q + CoordW'(1);
      min_d  = min_step_c;
      err_d  = err_step_c;
      left_d = left_q - CoordW'(1);
      last_d = left_q == '0;
    end

    out_valid_d     = out_load || (out_valid_q && !out_ready_i);
    out_read_data_d = out_read_data_q;
    out_count_d     = out_count_q;
    if (out_load) begin
      out_read_data_d = (kind_q == KIND_READ && rd_ok_q) ? rdata_q : '0;
      out_count_d     = (kind_q == KIND_READ) ? '0 : cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q          <= addr_d;
    rd_ok_q         <= rd_ok_d;
    kind_q          <= kind_d;
    steep_q         <= steep_d;
    ystep_neg_q     <= ystep_neg_d;
    pen_q           <= pen_d;
    dx_q            <= dx_d;
    dy_q            <= dy_d;
    maj_q           <= maj_d;
    min_q           <= min_d;
    err_q           <= err_d;
    left_q          <= left_d;
    last_q          <= last_d;
    mask_q          <= mask_d;
    on_q            <= on_d;
    view_q          <= view_d;
    cnt_q           <= cnt_d;
    out_read_data_q <= out_read_data_d;
    out_count_q     <= out_count_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_store_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= frame_store_q[addr_q];
  end

endmodule

`default_nettype wire

// ===== design/dlr_checker.sv =====
// Port-level checks of the dithered line rasterizer and their binding.
`default_nettype none

module dlr_checker import dlr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_i,
  input logic                m_axis_tvalid_i,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_i
);

  logic [2:0] pend_q, pend_d;
  logic       in_beat, out_beat;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_i;
  assign out_beat = m_axis_tvalid_i && m_axis_tready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_beat && !out_beat) begin
      pend_d = pend_q + 3'd1;
    end else if (out_beat && !in_beat) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result beat changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> pend_q != 3'd0)
    else $error("result beat without an accepted item");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'(MaxPending))
    else $error("more items in flight than the block can hold");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[7:0] == 8'd0 || m_axis_tdata_i[19:8] == 12'd0)
    else $error("result carries both read data and a pixel count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[19:8] <= 12'd2048 && m_axis_tdata_i[23:20] == 4'd0)
    else $error("pixel count out of range or padding not zero");

endmodule

bind dithered_line_rasterizer dlr_checker u_dlr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire
